// ===== hw/rtl/eslfs_pkg.sv =====
// package for the encoder synced line fire sequencer
// holds sequencer states, event codes, register indexes and defaults; no dependencies
`timescale 1ns / 1ps

package eslfs_pkg;

  localparam int LOST_DEPTH_DEF = 32;
  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

  localparam logic [2:0] FUNC_START = 3'd0;
  localparam logic [2:0] FUNC_TICK  = 3'd1;
  localparam logic [2:0] FUNC_FIRE  = 3'd2;
  localparam logic [2:0] FUNC_CYCLE = 3'd3;
  localparam logic [2:0] FUNC_LOAD  = 3'd4;
  localparam logic [2:0] FUNC_READ  = 3'd5;

  localparam logic [1:0] REG_FIRST_TICK = 2'd0;
  localparam logic [1:0] REG_TPF        = 2'd1;
  localparam logic [1:0] REG_FPP        = 2'd2;

  localparam logic [31:0] FIRST_TICK_RST = 32'd0;
  localparam logic [15:0] TPF_RST        = 16'd1;
  localparam logic [15:0] FPP_RST        = 16'd1;

  localparam logic [5:0] DIV_LAST = 6'd32;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV_A,
    ST_MUL_A,
    ST_DIV_B,
    ST_MUL_B,
    ST_LSET,
    ST_LOSS,
    ST_READ,
    ST_FIN
  } state_t;

endpackage

// ===== hw/rtl/eslfs_if.sv =====
// request and result channel interfaces for the line fire sequencer
// valid/ready handshake with payload; no dependencies
`timescale 1ns / 1ps

interface eslfs_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         func;
  logic signed [31:0] enc_position;
  logic [31:0]        loaded_line;
  logic [4:0]         lost_index;
  modport source (output valid, func, enc_position, loaded_line, lost_index, input ready);
  modport sink (input valid, func, enc_position, loaded_line, lost_index, output ready);
endinterface

interface eslfs_out_if;
  logic        valid;
  logic        ready;
  logic        stop_timer;
  logic        load_request;
  logic [31:0] load_line_number;
  logic        load_wait_fired;
  logic        load_error;
  logic        burst_started;
  logic        tick_ignored;
  logic [31:0] lost_total;
  logic [31:0] printed_total;
  logic [31:0] lost_entry;
  modport source (output valid, stop_timer, load_request, load_line_number, load_wait_fired,
                  load_error, burst_started, tick_ignored, lost_total, printed_total,
                  lost_entry, input ready);
  modport sink (input valid, stop_timer, load_request, load_line_number, load_wait_fired,
                load_error, burst_started, tick_ignored, lost_total, printed_total,
                lost_entry, output ready);
endinterface

// ===== hw/rtl/encoder_synced_line_fire_sequencer.sv =====
// flow: a request is accepted in idle and passes exec, read and finish into the result
// register; a forward-jump tick adds two serial divider runs, two multiply steps, a loss
// setup step and one lost-store write per skipped line (up to LOST_DEPTH)
// one request at a time; the result register lets the next request enter while a
// result is held. reset: rst_n synchronous active low; store entries are qualified
// by the lost count fill level, so no clearing pass is needed
`timescale 1ns / 1ps

module encoder_synced_line_fire_sequencer #(
  parameter int LOST_DEPTH = eslfs_pkg::LOST_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  eslfs_in_if.sink    in_ch,
  eslfs_out_if.source out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int AW = (LOST_DEPTH > 1) ? $clog2(LOST_DEPTH) : 1;

  eslfs_pkg::state_t state_r, state_nxt;

  // configuration
  logic [31:0] first_r;
  logic [15:0] tpf_r, fpp_r;
  logic [15:0] tpf_e, fpp_e;

  // sequencer state
  logic        armed_r, armed_nxt;
  logic [15:0] rem_fires_r, rem_fires_nxt;
  logic [31:0] expected_r, expected_nxt;
  logic [31:0] last_printed_r, last_printed_nxt;
  logic [31:0] lost_cnt_r, lost_cnt_nxt;
  logic [31:0] printed_r, printed_nxt;
  logic        pending_r, pending_nxt;
  logic [31:0] last_queued_r, last_queued_nxt;
  logic [31:0] last_loaded_r, last_loaded_nxt;
  logic [31:0] issued_r, issued_nxt;

  // request capture
  logic [2:0]  func_r;
  logic [31:0] enc_r, ldl_r;
  logic [4:0]  idx_r;

  // result flags
  logic        abort_r, abort_nxt;
  logic        lreq_r, lreq_nxt;
  logic [31:0] lline_r, lline_nxt;
  logic        lwait_r, lwait_nxt;
  logic        lerr_r, lerr_nxt;
  logic        burst_r, burst_nxt;
  logic        tign_r, tign_nxt;

  // divider, multiplier, loss loop
  logic [32:0] dvd_r, dvd_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        neg_r, neg_nxt;
  logic [31:0] dm_r, dm_nxt;
  logic [31:0] line_r, line_nxt;
  logic [31:0] next_r, next_nxt;
  logic [31:0] n_r, n_nxt;
  logic [31:0] k_r, k_nxt;

  logic [31:0] mem [LOST_DEPTH];
  logic [31:0] rd_q;
  logic        mem_we;

  // output register
  logic        out_valid_r;
  logic        out_abort_r, out_lreq_r, out_lwait_r, out_lerr_r, out_burst_r, out_tign_r;
  logic [31:0] out_lline_r, out_lost_r, out_printed_r, out_entry_r;

  logic        accept, ahead, out_free, loss_go;
  logic [32:0] d_ext, d_mag;
  logic [16:0] rem_sh;
  logic        ge;
  logic [31:0] q1;
  logic [31:0] mul_a;
  logic [15:0] mul_b;
  logic [47:0] prod;
  logic [31:0] start_l, j_off;
  logic        req_en, req_wait;
  logic [31:0] req_line;
  logic [32:0] lost_sum;
  logic [32:0] printed_sum;
  logic [31:0] entry;
  logic [31:0] idx_ext;

  assign tpf_e = (tpf_r == 16'd0) ? 16'd1 : tpf_r;
  assign fpp_e = (fpp_r == 16'd0) ? 16'd1 : fpp_r;

  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign ahead    = (func_r == eslfs_pkg::FUNC_TICK) && armed_r &&
                    ($signed(enc_r) > $signed(expected_r));

  assign d_ext   = {enc_r[31], enc_r} - {first_r[31], first_r};
  assign d_mag   = d_ext[32] ? (~d_ext + 33'd1) : d_ext;
  assign rem_sh  = {rem_r, dvd_r[32]};
  assign ge      = rem_sh >= {1'b0, tpf_e};
  // signed quotient plus one, truncated to 32 bits
  assign q1      = neg_r ? (~dvd_r[31:0] + 32'd2) : (dvd_r[31:0] + 32'd1);
  assign mul_a   = (state_r == eslfs_pkg::ST_MUL_A) ? q1 : dvd_r[31:0];
  assign mul_b   = (state_r == eslfs_pkg::ST_MUL_A) ? tpf_e : fpp_e;
  assign prod    = mul_a * mul_b;
  assign start_l = last_printed_r + 32'd1;
  assign j_off   = k_r - lost_cnt_r;
  assign loss_go = (k_r < 32'(LOST_DEPTH)) && (j_off < n_r);
  assign mem_we  = (state_r == eslfs_pkg::ST_LOSS) && loss_go;
  assign idx_ext = {27'd0, idx_r};
  assign entry   = ((idx_ext < 32'(LOST_DEPTH)) && (idx_ext < lost_cnt_r)) ? rd_q
                                                                          : eslfs_pkg::ALL_ONES;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      eslfs_pkg::ST_IDLE:  if (in_ch.valid) state_nxt = eslfs_pkg::ST_EXEC;
      eslfs_pkg::ST_EXEC:  state_nxt = ahead ? eslfs_pkg::ST_DIV_A : eslfs_pkg::ST_READ;
      eslfs_pkg::ST_DIV_A: if (cnt_r == eslfs_pkg::DIV_LAST) state_nxt = eslfs_pkg::ST_MUL_A;
      eslfs_pkg::ST_MUL_A: state_nxt = eslfs_pkg::ST_DIV_B;
      eslfs_pkg::ST_DIV_B: if (cnt_r == eslfs_pkg::DIV_LAST) state_nxt = eslfs_pkg::ST_MUL_B;
      eslfs_pkg::ST_MUL_B: state_nxt = eslfs_pkg::ST_LSET;
      eslfs_pkg::ST_LSET:  state_nxt = eslfs_pkg::ST_LOSS;
      eslfs_pkg::ST_LOSS:  if (!loss_go) state_nxt = eslfs_pkg::ST_READ;
      eslfs_pkg::ST_READ:  state_nxt = eslfs_pkg::ST_FIN;
      eslfs_pkg::ST_FIN:   if (out_free) state_nxt = eslfs_pkg::ST_IDLE;
      default:             state_nxt = eslfs_pkg::ST_IDLE;
    endcase
  end

  assign in_ch.ready = (state_r == eslfs_pkg::ST_IDLE);

  // datapath
  always_comb begin
    armed_nxt        = armed_r;
    rem_fires_nxt    = rem_fires_r;
    expected_nxt     = expected_r;
    last_printed_nxt = last_printed_r;
    lost_cnt_nxt     = lost_cnt_r;
    printed_nxt      = printed_r;
    pending_nxt      = pending_r;
    last_queued_nxt  = last_queued_r;
    last_loaded_nxt  = last_loaded_r;
    issued_nxt       = issued_r;
    abort_nxt        = abort_r;
    lreq_nxt         = lreq_r;
    lline_nxt        = lline_r;
    lwait_nxt        = lwait_r;
    lerr_nxt         = lerr_r;
    burst_nxt        = burst_r;
    tign_nxt         = tign_r;
    dvd_nxt          = dvd_r;
    rem_nxt          = rem_r;
    cnt_nxt          = cnt_r;
    neg_nxt          = neg_r;
    dm_nxt           = dm_r;
    line_nxt         = line_r;
    next_nxt         = next_r;
    n_nxt            = n_r;
    k_nxt            = k_r;
    req_en           = 1'b0;
    req_wait         = 1'b0;
    req_line         = 32'd0;
    lost_sum         = {1'b0, lost_cnt_r} + {1'b0, n_r};
    printed_sum      = {1'b0, printed_r} + 33'd1;

    unique case (state_r)
      eslfs_pkg::ST_IDLE: begin
        if (accept) begin
          abort_nxt = 1'b0;
          lreq_nxt  = 1'b0;
          lline_nxt = 32'd0;
          lwait_nxt = 1'b0;
          lerr_nxt  = 1'b0;
          burst_nxt = 1'b0;
          tign_nxt  = 1'b0;
        end
      end
      eslfs_pkg::ST_EXEC: begin
        unique case (func_r)
          eslfs_pkg::FUNC_START: begin
            rem_fires_nxt    = 16'd0;
            expected_nxt     = first_r;
            last_printed_nxt = eslfs_pkg::ALL_ONES;
            lost_cnt_nxt     = 32'd0;
            printed_nxt      = 32'd0;
            pending_nxt      = 1'b0;
            armed_nxt        = 1'b1;
            req_en           = 1'b1;
          end
          eslfs_pkg::FUNC_TICK: begin
            if (!armed_r) begin
              tign_nxt = 1'b1;
            end else if ($signed(enc_r) < $signed(expected_r)) begin
              abort_nxt = 1'b1;
            end else if (ahead) begin
              abort_nxt = 1'b1;
              neg_nxt   = d_ext[32];
              dvd_nxt   = d_mag;
              rem_nxt   = 16'd0;
              cnt_nxt   = 6'd0;
            end else if (last_queued_r != last_loaded_r) begin
              abort_nxt = 1'b1;
            end else begin
              rem_fires_nxt = fpp_e;
              burst_nxt     = 1'b1;
              armed_nxt     = 1'b0;
            end
          end
          eslfs_pkg::FUNC_FIRE: begin
            issued_nxt = last_queued_r;
            req_en     = 1'b1;
            req_wait   = 1'b1;
            req_line   = last_queued_r + 32'd1;
          end
          eslfs_pkg::FUNC_CYCLE: begin
            last_printed_nxt = issued_r;
            printed_nxt      = printed_sum[32] ? eslfs_pkg::ALL_ONES : printed_sum[31:0];
            if (rem_fires_r > 16'd1) begin
              if (last_queued_r != last_loaded_r) begin
                abort_nxt     = 1'b1;
                rem_fires_nxt = 16'd0;
                armed_nxt     = 1'b1;
              end else begin
                rem_fires_nxt = rem_fires_r - 16'd1;
              end
            end else if (rem_fires_r == 16'd1) begin
              abort_nxt     = 1'b1;
              rem_fires_nxt = 16'd0;
              expected_nxt  = expected_r + {16'd0, tpf_e};
              armed_nxt     = 1'b1;
            end
          end
          eslfs_pkg::FUNC_LOAD: begin
            pending_nxt     = 1'b0;
            last_loaded_nxt = ldl_r;
          end
          default: ;
        endcase
      end
      eslfs_pkg::ST_DIV_A, eslfs_pkg::ST_DIV_B: begin
        rem_nxt = ge ? 16'(rem_sh - {1'b0, tpf_e}) : rem_sh[15:0];
        dvd_nxt = {dvd_r[31:0], ge};
        cnt_nxt = cnt_r + 6'd1;
      end
      eslfs_pkg::ST_MUL_A: begin
        // distance from the first tick to the next print position
        dm_nxt  = prod[31:0];
        dvd_nxt = {1'b0, prod[31:0]};
        rem_nxt = 16'd0;
        cnt_nxt = 6'd0;
      end
      eslfs_pkg::ST_MUL_B: begin
        line_nxt = prod[31:0];
        next_nxt = first_r + dm_r;
      end
      eslfs_pkg::ST_LSET: begin
        n_nxt = (line_r > start_l) ? (line_r - start_l) : 32'd0;
        k_nxt = lost_cnt_r;
      end
      eslfs_pkg::ST_LOSS: begin
        if (loss_go) begin
          k_nxt = k_r + 32'd1;
        end else begin
          lost_cnt_nxt = lost_sum[32] ? eslfs_pkg::ALL_ONES : lost_sum[31:0];
          req_en       = 1'b1;
          req_line     = line_r;
          expected_nxt = next_r;
          armed_nxt    = 1'b1;
        end
      end
      eslfs_pkg::ST_READ: ;
      eslfs_pkg::ST_FIN:  ;
      default: ;
    endcase

    // single-slot load pipeline
    if (req_en) begin
      if (pending_nxt) begin
        lerr_nxt = 1'b1;
      end else begin
        pending_nxt     = 1'b1;
        last_queued_nxt = req_line;
        lreq_nxt        = 1'b1;
        lline_nxt       = req_line;
        lwait_nxt       = req_wait;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= eslfs_pkg::ST_IDLE;
      first_r        <= eslfs_pkg::FIRST_TICK_RST;
      tpf_r          <= eslfs_pkg::TPF_RST;
      fpp_r          <= eslfs_pkg::FPP_RST;
      armed_r        <= 1'b1;
      rem_fires_r    <= 16'd0;
      expected_r     <= 32'd0;
      last_printed_r <= eslfs_pkg::ALL_ONES;
      lost_cnt_r     <= 32'd0;
      printed_r      <= 32'd0;
      pending_r      <= 1'b0;
      last_queued_r  <= 32'd0;
      last_loaded_r  <= eslfs_pkg::ALL_ONES;
      issued_r       <= 32'd0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      armed_r        <= armed_nxt;
      rem_fires_r    <= rem_fires_nxt;
      expected_r     <= expected_nxt;
      last_printed_r <= last_printed_nxt;
      lost_cnt_r     <= lost_cnt_nxt;
      printed_r      <= printed_nxt;
      pending_r      <= pending_nxt;
      last_queued_r  <= last_queued_nxt;
      last_loaded_r  <= last_loaded_nxt;
      issued_r       <= issued_nxt;
      if (cfg_psel && cfg_penable && cfg_pwrite) begin
        unique case (cfg_paddr[3:2])
          eslfs_pkg::REG_FIRST_TICK: first_r <= cfg_pwdata;
          eslfs_pkg::REG_TPF:        tpf_r   <= cfg_pwdata[15:0];
          eslfs_pkg::REG_FPP:        fpp_r   <= cfg_pwdata[15:0];
          default: ;
        endcase
      end
      if (state_r == eslfs_pkg::ST_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      func_r <= in_ch.func;
      enc_r  <= in_ch.enc_position;
      ldl_r  <= in_ch.loaded_line;
      idx_r  <= in_ch.lost_index;
    end
    abort_r <= abort_nxt;
    lreq_r  <= lreq_nxt;
    lline_r <= lline_nxt;
    lwait_r <= lwait_nxt;
    lerr_r  <= lerr_nxt;
    burst_r <= burst_nxt;
    tign_r  <= tign_nxt;
    dvd_r   <= dvd_nxt;
    rem_r   <= rem_nxt;
    cnt_r   <= cnt_nxt;
    neg_r   <= neg_nxt;
    dm_r    <= dm_nxt;
    line_r  <= line_nxt;
    next_r  <= next_nxt;
    n_r     <= n_nxt;
    k_r     <= k_nxt;
    if (state_r == eslfs_pkg::ST_FIN && out_free) begin
      out_abort_r   <= abort_r;
      out_lreq_r    <= lreq_r;
      out_lline_r   <= lline_r;
      out_lwait_r   <= lwait_r;
      out_lerr_r    <= lerr_r;
      out_burst_r   <= burst_r;
      out_tign_r    <= tign_r;
      out_lost_r    <= lost_cnt_r;
      out_printed_r <= printed_r;
      out_entry_r   <= entry;
    end
  end

  // lost line store, entries at or above the lost count read as all ones
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[k_r[AW-1:0]] <= start_l + j_off;
    end
    rd_q <= mem[idx_ext[AW-1:0]];
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      eslfs_pkg::REG_FIRST_TICK: cfg_prdata = first_r;
      eslfs_pkg::REG_TPF:        cfg_prdata = {16'd0, tpf_r};
      eslfs_pkg::REG_FPP:        cfg_prdata = {16'd0, fpp_r};
      default:                   cfg_prdata = 32'd0;
    endcase
  end

  assign cfg_pready = 1'b1;

  assign out_ch.valid            = out_valid_r;
  assign out_ch.stop_timer       = out_abort_r;
  assign out_ch.load_request     = out_lreq_r;
  assign out_ch.load_line_number = out_lline_r;
  assign out_ch.load_wait_fired  = out_lwait_r;
  assign out_ch.load_error       = out_lerr_r;
  assign out_ch.burst_started    = out_burst_r;
  assign out_ch.tick_ignored     = out_tign_r;
  assign out_ch.lost_total       = out_lost_r;
  assign out_ch.printed_total    = out_printed_r;
  assign out_ch.lost_entry       = out_entry_r;

endmodule

// ===== hw/rtl/eslfs_checker.sv =====
// port-level assertions for the line fire sequencer
// bound to encoder_synced_line_fire_sequencer; uses its channel interfaces
`timescale 1ns / 1ps

module eslfs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        stop_timer,
  input logic        load_request,
  input logic [31:0] load_line_number,
  input logic        load_wait_fired,
  input logic        load_error,
  input logic        burst_started
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while one is at work");

  a_req_xor_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(load_request && load_error))
    else $error("load request and load error together");

  a_no_req_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !load_request |-> load_line_number == 32'd0 && !load_wait_fired)
    else $error("load fields set without a load request");

  a_burst_no_abort: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && burst_started |-> !stop_timer)
    else $error("burst start with abort");

endmodule

bind encoder_synced_line_fire_sequencer eslfs_checker u_eslfs_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .stop_timer       (out_ch.stop_timer),
  .load_request     (out_ch.load_request),
  .load_line_number (out_ch.load_line_number),
  .load_wait_fired  (out_ch.load_wait_fired),
  .load_error       (out_ch.load_error),
  .burst_started    (out_ch.burst_started)
);

// ===== tb/sv/testbench.sv =====
// self-checking testbench for the encoder synced line fire sequencer
// depends on eslfs_pkg, the eslfs_in_if/eslfs_out_if interfaces and the sequencer rtl
`timescale 1ns / 1ps

module testbench;

  typedef struct packed {
    logic        stop_timer;
    logic        load_request;
    logic [31:0] load_line_number;
    logic        load_wait_fired;
    logic        load_error;
    logic        burst_started;
    logic        tick_ignored;
    logic [31:0] lost_total;
    logic [31:0] printed_total;
    logic [31:0] lost_entry;
  } fire_result_t;

  class fire_scoreboard;
    // sequencer state mirror
    logic [31:0] first_tick;
    logic [15:0] tpf;
    logic [15:0] fpp;
    logic        armed;
    logic [15:0] remaining;
    logic [31:0] exp_tick;
    logic [31:0] last_printed;
    logic [31:0] lost_cnt;
    logic [31:0] printed_cnt;
    logic        load_pending;
    logic [31:0] last_queued;
    logic [31:0] last_loaded;
    logic [31:0] issued;
    logic [31:0] lost_store[32];
    fire_result_t pending_results[$];
    int errors;

    function void reset_state();
      first_tick = eslfs_pkg::FIRST_TICK_RST; tpf = eslfs_pkg::TPF_RST;
      fpp = eslfs_pkg::FPP_RST;
      armed = 1; remaining = 0; exp_tick = 0; last_printed = eslfs_pkg::ALL_ONES;
      lost_cnt = 0; printed_cnt = 0; load_pending = 0; last_queued = 0;
      last_loaded = eslfs_pkg::ALL_ONES; issued = 0; errors = 0;
      foreach (lost_store[i]) lost_store[i] = eslfs_pkg::ALL_ONES;
    endfunction

    function logic [31:0] sat_inc(logic [31:0] a, logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? eslfs_pkg::ALL_ONES : s[31:0];
    endfunction

    function void request_line(inout fire_result_t r, input logic [31:0] line,
                               input logic wait_fire);
      if (load_pending) begin
        r.load_error = 1;
      end else begin
        load_pending = 1; last_queued = line;
        r.load_request = 1; r.load_line_number = line; r.load_wait_fired = wait_fire;
      end
    endfunction

    function void note_request(logic [2:0] func, logic [31:0] enc, logic [31:0] ldl,
                               logic [4:0] idx);
      fire_result_t r;
      longint e, x, f, t, q, nx;
      logic [31:0] next, line, start, n, t32, p32;
      r = '0;
      t32 = (tpf == 0) ? 32'd1 : {16'd0, tpf};
      p32 = (fpp == 0) ? 32'd1 : {16'd0, fpp};
      case (func)
        eslfs_pkg::FUNC_START: begin
          remaining = 0; exp_tick = first_tick; last_printed = eslfs_pkg::ALL_ONES;
          lost_cnt = 0; printed_cnt = 0; load_pending = 0; armed = 1;
          foreach (lost_store[i]) lost_store[i] = eslfs_pkg::ALL_ONES;
          request_line(r, 32'd0, 1'b0);
        end
        eslfs_pkg::FUNC_TICK: begin
          if (!armed) begin
            r.tick_ignored = 1;
          end else begin
            armed = 0;
            e = longint'($signed(enc)); x = longint'($signed(exp_tick));
            if (e < x) begin
              r.stop_timer = 1; armed = 1;
            end else if (e > x) begin
              r.stop_timer = 1;
              f = longint'($signed(first_tick)); t = longint'(t32);
              q = (e - f) / t;
              nx = f + q * t + t;
              next = nx[31:0];
              line = ((next - first_tick) / t32) * p32;
              start = last_printed + 1;
              n = (line > start) ? line - start : 32'd0;
              for (int k = 0; k < 32; k++)
                if (k >= lost_cnt && (k - lost_cnt) < n)
                  lost_store[k] = start + (k - lost_cnt);
              lost_cnt = sat_inc(lost_cnt, n);
              request_line(r, line, 1'b0);
              exp_tick = next; armed = 1;
            end else if (last_queued != last_loaded) begin
              r.stop_timer = 1; armed = 1;
            end else begin
              remaining = p32[15:0]; r.burst_started = 1;
            end
          end
        end
        eslfs_pkg::FUNC_FIRE: begin
          issued = last_queued;
          request_line(r, last_queued + 1, 1'b1);
        end
        eslfs_pkg::FUNC_CYCLE: begin
          last_printed = issued;
          printed_cnt = sat_inc(printed_cnt, 1);
          if (remaining > 1) begin
            if (last_queued != last_loaded) begin
              r.stop_timer = 1; remaining = 0; armed = 1;
            end else begin
              remaining--;
            end
          end else if (remaining == 1) begin
            r.stop_timer = 1; remaining = 0; exp_tick += t32; armed = 1;
          end
        end
        eslfs_pkg::FUNC_LOAD: begin
          load_pending = 0; last_loaded = ldl;
        end
        default: ;
      endcase
      r.lost_total = lost_cnt; r.printed_total = printed_cnt;
      r.lost_entry = lost_store[idx];
      pending_results.push_back(r);
    endfunction

    function void check_result(fire_result_t a);
      fire_result_t x;
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
        return;
      end
      x = pending_results.pop_front();
      if (a.stop_timer !== x.stop_timer) begin
        $error("stop_timer exp %0h got %0h", x.stop_timer, a.stop_timer); errors++;
      end
      if (a.load_request !== x.load_request) begin
        $error("load_request exp %0h got %0h", x.load_request, a.load_request); errors++;
      end
      if (a.load_line_number !== x.load_line_number) begin
        $error("load_line_number exp %0h got %0h", x.load_line_number, a.load_line_number);
        errors++;
      end
      if (a.load_wait_fired !== x.load_wait_fired) begin
        $error("load_wait_fired exp %0h got %0h", x.load_wait_fired, a.load_wait_fired);
        errors++;
      end
      if (a.load_error !== x.load_error) begin
        $error("load_error exp %0h got %0h", x.load_error, a.load_error); errors++;
      end
      if (a.burst_started !== x.burst_started) begin
        $error("burst_started exp %0h got %0h", x.burst_started, a.burst_started); errors++;
      end
      if (a.tick_ignored !== x.tick_ignored) begin
        $error("tick_ignored exp %0h got %0h", x.tick_ignored, a.tick_ignored); errors++;
      end
      if (a.lost_total !== x.lost_total) begin
        $error("lost_total exp %0h got %0h", x.lost_total, a.lost_total); errors++;
      end
      if (a.printed_total !== x.printed_total) begin
        $error("printed_total exp %0h got %0h", x.printed_total, a.printed_total); errors++;
      end
      if (a.lost_entry !== x.lost_entry) begin
        $error("lost_entry exp %0h got %0h", x.lost_entry, a.lost_entry); errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_psel, cfg_penable, cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  int          cycle_count;
  int          hold_off;
  bit          quiet_phase;
  fire_scoreboard sb;

  eslfs_in_if  in_ch ();
  eslfs_out_if out_ch ();

  encoder_synced_line_fire_sequencer u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 400000) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // result side: random stalls, plus a long hold-off when requested
  initial begin
    fire_result_t r;
    int gap;
    out_ch.ready = 0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        r.stop_timer = out_ch.stop_timer; r.load_request = out_ch.load_request;
        r.load_line_number = out_ch.load_line_number;
        r.load_wait_fired = out_ch.load_wait_fired; r.load_error = out_ch.load_error;
        r.burst_started = out_ch.burst_started; r.tick_ignored = out_ch.tick_ignored;
        r.lost_total = out_ch.lost_total; r.printed_total = out_ch.printed_total;
        r.lost_entry = out_ch.lost_entry;
        sb.check_result(r);
      end
      @(negedge clk);
      if (hold_off > 0) begin
        hold_off--;
        out_ch.ready = 0;
      end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 15);
        out_ch.ready = 0;
        repeat (gap - 1) @(negedge clk);
      end else begin
        out_ch.ready = 1;
      end
    end
  end

  task automatic cfg_write(logic [1:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_psel = 1; cfg_penable = 0; cfg_pwrite = 1;
    cfg_paddr = {idx, 2'b00}; cfg_pwdata = data;
    @(negedge clk);
    cfg_penable = 1;
    @(negedge clk);
    cfg_psel = 0; cfg_penable = 0; cfg_pwrite = 0;
    case (idx)
      eslfs_pkg::REG_FIRST_TICK: sb.first_tick = data;
      eslfs_pkg::REG_TPF:        sb.tpf = data[15:0];
      default:                   sb.fpp = data[15:0];
    endcase
  endtask

  task automatic send_request(logic [2:0] func, logic [31:0] enc, logic [31:0] ldl,
                              logic [4:0] idx);
    int gap;
    if (!quiet_phase && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 15);
      in_ch.valid = 0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid = 1; in_ch.func = func; in_ch.enc_position = enc;
    in_ch.loaded_line = ldl; in_ch.lost_index = idx;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_request(func, enc, ldl, idx);
    @(negedge clk);
    in_ch.valid = 0;
  endtask

  task automatic drain();
    while (sb.pending_results.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  // one random request: start, tick (equal, behind, ahead or random), fire, cycle, load, read or an unused code
  task automatic random_request(int ahead);
    logic [2:0] f;
    logic [31:0] enc;
    int pick;
    pick = $urandom_range(0, 99);
    enc = sb.exp_tick;
    if (pick < 4) f = eslfs_pkg::FUNC_START;
    else if (pick < 35) begin
      f = eslfs_pkg::FUNC_TICK;
      case ($urandom_range(0, 5))
        0: enc = $urandom;
        1: enc = sb.exp_tick - $urandom_range(1, 3);
        2: enc = sb.exp_tick + $urandom_range(1, ahead);
        default: enc = sb.exp_tick;
      endcase
    end
    else if (pick < 55) f = eslfs_pkg::FUNC_FIRE;
    else if (pick < 75) f = eslfs_pkg::FUNC_CYCLE;
    else if (pick < 93) f = eslfs_pkg::FUNC_LOAD;
    else if (pick < 98) f = eslfs_pkg::FUNC_READ;
    else f = 3'($urandom_range(6, 7));
    send_request(f, enc, ($urandom_range(0, 3) == 0) ? $urandom : sb.last_queued,
                 5'($urandom));
  endtask

  initial begin
    sb = new();
    sb.reset_state();
    rst_n = 0; hold_off = 0; quiet_phase = 0;
    cfg_psel = 0; cfg_penable = 0; cfg_pwrite = 0; cfg_paddr = 0; cfg_pwdata = 0;
    in_ch.valid = 0; in_ch.func = 0; in_ch.enc_position = 0;
    in_ch.loaded_line = 0; in_ch.lost_index = 0;
    repeat (8) @(negedge clk);
    rst_n = 1;

    // directed: reset defaults, every event, tick cases, reads of the lost store
    send_request(eslfs_pkg::FUNC_READ, 0, 0, 5'd31);
    send_request(eslfs_pkg::FUNC_TICK, 0, 0, 0);            // tick equal, load outstanding
    send_request(eslfs_pkg::FUNC_START, 0, 0, 0);
    send_request(eslfs_pkg::FUNC_START, 0, 0, 0);           // load error while pending
    send_request(eslfs_pkg::FUNC_LOAD, 0, 0, 0);
    send_request(eslfs_pkg::FUNC_TICK, 32'h8000_0000, 0, 0);  // behind expected
    send_request(eslfs_pkg::FUNC_TICK, 0, 0, 0);            // match
    send_request(eslfs_pkg::FUNC_TICK, 0, 0, 0);            // ignored while burst
    send_request(eslfs_pkg::FUNC_FIRE, 0, 0, 0);
    send_request(eslfs_pkg::FUNC_CYCLE, 0, 0, 0);
    send_request(eslfs_pkg::FUNC_LOAD, 1, 0, 0);
    send_request(eslfs_pkg::FUNC_TICK, 10, 0, 0);           // forward jump, lines lost
    send_request(eslfs_pkg::FUNC_READ, 0, 0, 5'd0);
    send_request(eslfs_pkg::FUNC_READ, 0, 0, 5'd5);
    send_request(eslfs_pkg::FUNC_LOAD, 0, 32'hFFFF_FFFF, 0);
    send_request(eslfs_pkg::FUNC_TICK, 32'h7FFF_FFFF, 0, 0);  // far jump, lost store fills
    send_request(eslfs_pkg::FUNC_READ, 0, 0, 5'd31);
    send_request(eslfs_pkg::FUNC_CYCLE, 0, 0, 0);
    send_request(3'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'h1F);
    send_request(3'd7, 0, 0, 0);
    drain();

    // setting phases: extremes first, then random
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: begin
          cfg_write(eslfs_pkg::REG_FIRST_TICK, 32'h8000_0000);
          cfg_write(eslfs_pkg::REG_TPF, 32'd65535); cfg_write(eslfs_pkg::REG_FPP, 32'd65535);
        end
        1: begin
          cfg_write(eslfs_pkg::REG_FIRST_TICK, 32'h7FFF_FFFF);
          cfg_write(eslfs_pkg::REG_TPF, 32'd1); cfg_write(eslfs_pkg::REG_FPP, 32'd1);
        end
        2: begin
          cfg_write(eslfs_pkg::REG_FIRST_TICK, 32'hFFFF_FFF0);
          cfg_write(eslfs_pkg::REG_TPF, 32'd4); cfg_write(eslfs_pkg::REG_FPP, 32'd3);
        end
        default: begin
          cfg_write(eslfs_pkg::REG_FIRST_TICK,
                    ($urandom_range(0, 1)) ? $urandom : $urandom_range(0, 50));
          cfg_write(eslfs_pkg::REG_TPF,
                    ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, 8));
          cfg_write(eslfs_pkg::REG_FPP,
                    ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, 4));
        end
      endcase
      send_request(eslfs_pkg::FUNC_START, 0, 0, 0);
      if (ph == 4) hold_off = 300;
      if (ph >= 8) quiet_phase = 1;
      for (int i = 0; i < 50; i++)
        random_request((ph == 0) ? 200000 : 3 * (sb.tpf + 1));
      drain();
    end

    if (sb.errors == 0 && sb.pending_results.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
